FILE: sv/srt_pkg.sv
// srt_pkg: shared constants, types and codes for the sorted record table.
// Used by srt_cell and sorted_record_table; depends on nothing.
package srt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int YEAR_W   = 16;
  localparam int FLOW_W   = 32;
  localparam int STAT_W   = 3;
  localparam int RCNT_W   = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     exec;
    logic [1:0]               op;
    logic                     ins_ok;
    logic [YEAR_W-1:0]        year;
    logic signed [FLOW_W-1:0] flow;
    logic [POS_W-1:0]         pos;
    logic [CNT_W-1:0]         count;
  } srt_ctrl_t;

endpackage

FILE: sv/srt_cell.sv
// srt_cell: one slot of the sorted chain; holds one record, compares it with
// the broadcast key and shifts to/from its neighbors. Depends on srt_pkg.
module srt_cell (
  input  logic                             clk,
  input  srt_pkg::srt_ctrl_t               ctrl,
  input  logic [srt_pkg::IDX_W-1:0]        index,
  input  logic                             left_gt,
  input  logic [srt_pkg::YEAR_W-1:0]       left_year,
  input  logic signed [srt_pkg::FLOW_W-1:0] left_flow,
  input  logic [srt_pkg::YEAR_W-1:0]       right_year,
  input  logic signed [srt_pkg::FLOW_W-1:0] right_flow,
  input  logic                             seen_in,
  output logic                             gt,
  output logic                             seen_out,
  output logic [srt_pkg::YEAR_W-1:0]       rd_year,
  output logic signed [srt_pkg::FLOW_W-1:0] rd_flow,
  output logic [srt_pkg::YEAR_W-1:0]       year,
  output logic signed [srt_pkg::FLOW_W-1:0] flow
);

  logic                              valid;
  logic                              match;
  logic                              hit;
  logic [srt_pkg::YEAR_W-1:0]        year_next;
  logic signed [srt_pkg::FLOW_W-1:0] flow_next;

  assign valid    = srt_pkg::CNT_W'(index) < ctrl.count;
  assign gt       = valid && (ctrl.flow > flow);
  assign match    = valid && (ctrl.year == year);
  assign seen_out = seen_in | match;
  assign hit      = srt_pkg::CMP_W'(index) == srt_pkg::CMP_W'(ctrl.pos);
  assign rd_year  = hit ? year : '0;
  assign rd_flow  = hit ? flow : '0;

  always_comb begin
    year_next = year;
    flow_next = flow;
    if (ctrl.exec) begin
      case (ctrl.op)
        srt_pkg::OP_INSERT: begin
          // gt is true on a prefix of the chain; the key lands just past it
          if (ctrl.ins_ok && !gt) begin
            if (left_gt) begin
              year_next = ctrl.year;
              flow_next = ctrl.flow;
            end else begin
              year_next = left_year;
              flow_next = left_flow;
            end
          end
        end
        srt_pkg::OP_REMOVE: begin
          // from the first matching slot on, pull from the right
          if (seen_out) begin
            year_next = right_year;
            flow_next = right_flow;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    year <= year_next;
    flow <= flow_next;
  end

endmodule

FILE: sv/sorted_record_table.sv
// sorted_record_table: top level; controller plus a chain of srt_cell slots.
// Depends on srt_pkg and srt_cell.
//
// Usage:
//   Command channel: drive opcode, key_year, flow_value and read_position
//   with start high; the beat is taken at a clock edge where busy is low.
//   Opcodes: insert (kept sorted by ascending flow, newest first among
//   equal flows), remove first record with matching year, read the record
//   at a sorted position.
//   Result channel: status, found_year, found_flow and record_count are
//   valid for exactly one cycle while done is high. found_* are zero except
//   for a successful read.
//   Sequencing: the accepting edge moves the controller into S_EXEC, the
//   single update state in which every cell compares against the broadcast
//   key and shifts with its neighbors; done and the result are registered
//   at the end of that state. busy is high for one cycle after acceptance,
//   so a new command is not taken until the update state has finished.
//   The result is never held off; the receiver must take it when done is
//   high. A new command may be presented during the done cycle.
//   Reset (rst, synchronous) empties the table and clears done and busy;
//   record contents are not cleared, only the count.
module sorted_record_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic [srt_pkg::YEAR_W-1:0]         key_year,
  input  logic signed [srt_pkg::FLOW_W-1:0]  flow_value,
  input  logic [srt_pkg::POS_W-1:0]          read_position,
  output logic                               done,
  output logic [srt_pkg::STAT_W-1:0]         status,
  output logic [srt_pkg::YEAR_W-1:0]         found_year,
  output logic signed [srt_pkg::FLOW_W-1:0]  found_flow,
  output logic [srt_pkg::RCNT_W-1:0]         record_count
);

  localparam int N = srt_pkg::CAPACITY;

  srt_pkg::state_t state, state_next;

  logic [1:0]                        op_q;
  logic [srt_pkg::YEAR_W-1:0]        year_q;
  logic signed [srt_pkg::FLOW_W-1:0] flow_q;
  logic [srt_pkg::POS_W-1:0]         pos_q;
  logic [srt_pkg::CNT_W-1:0]         count, count_next;

  logic                              exec;
  logic                              full;
  logic                              accept;
  srt_pkg::srt_ctrl_t                ctrl;

  logic [N-1:0]                      gt;
  logic [N-1:0]                      seen;
  logic [srt_pkg::YEAR_W-1:0]        cell_year [N];
  logic signed [srt_pkg::FLOW_W-1:0] cell_flow [N];
  logic [srt_pkg::YEAR_W-1:0]        rd_year   [N];
  logic signed [srt_pkg::FLOW_W-1:0] rd_flow   [N];

  logic [srt_pkg::YEAR_W-1:0]        or_year;
  logic signed [srt_pkg::FLOW_W-1:0] or_flow;
  logic [srt_pkg::STAT_W-1:0]        status_next;
  logic                              rd_ok;

  assign busy   = (state == srt_pkg::S_EXEC);
  assign exec   = busy;
  assign accept = start && !busy;
  assign full   = (count == srt_pkg::CNT_W'(N));
  assign rd_ok  = srt_pkg::CMP_W'(pos_q) < srt_pkg::CMP_W'(count);

  always_comb begin
    ctrl.exec   = exec;
    ctrl.op     = op_q;
    ctrl.ins_ok = !full;
    ctrl.year   = year_q;
    ctrl.flow   = flow_q;
    ctrl.pos    = pos_q;
    ctrl.count  = count;
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic                              l_gt;
      logic                              l_seen;
      logic [srt_pkg::YEAR_W-1:0]        l_year, r_year;
      logic signed [srt_pkg::FLOW_W-1:0] l_flow, r_flow;

      if (i == 0) begin : g_head
        assign l_gt   = 1'b1;
        assign l_seen = 1'b0;
        assign l_year = cell_year[0];
        assign l_flow = cell_flow[0];
      end else begin : g_body
        assign l_gt   = gt[i-1];
        assign l_seen = seen[i-1];
        assign l_year = cell_year[i-1];
        assign l_flow = cell_flow[i-1];
      end

      if (i == N - 1) begin : g_tail
        assign r_year = cell_year[i];
        assign r_flow = cell_flow[i];
      end else begin : g_mid
        assign r_year = cell_year[i+1];
        assign r_flow = cell_flow[i+1];
      end

      srt_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .index      (srt_pkg::IDX_W'(i)),
        .left_gt    (l_gt),
        .left_year  (l_year),
        .left_flow  (l_flow),
        .right_year (r_year),
        .right_flow (r_flow),
        .seen_in    (l_seen),
        .gt         (gt[i]),
        .seen_out   (seen[i]),
        .rd_year    (rd_year[i]),
        .rd_flow    (rd_flow[i]),
        .year       (cell_year[i]),
        .flow       (cell_flow[i])
      );
    end
  endgenerate

  // at most one cell drives a nonzero read value
  always_comb begin
    or_year = '0;
    or_flow = '0;
    for (int k = 0; k < N; k++) begin
      or_year = or_year | rd_year[k];
      or_flow = or_flow | rd_flow[k];
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = srt_pkg::ST_RANGE;
    case (state)
      srt_pkg::S_IDLE: begin
        if (accept) state_next = srt_pkg::S_EXEC;
      end
      srt_pkg::S_EXEC: begin
        state_next = srt_pkg::S_IDLE;
        case (op_q)
          srt_pkg::OP_INSERT: begin
            if (full) begin
              status_next = srt_pkg::ST_FULL;
            end else begin
              status_next = srt_pkg::ST_INSERTED;
              count_next  = count + srt_pkg::CNT_W'(1);
            end
          end
          srt_pkg::OP_REMOVE: begin
            if (seen[N-1]) begin
              status_next = srt_pkg::ST_REMOVED;
              count_next  = count - srt_pkg::CNT_W'(1);
            end else begin
              status_next = srt_pkg::ST_NOT_FOUND;
            end
          end
          srt_pkg::OP_READ: begin
            status_next = rd_ok ? srt_pkg::ST_INSERTED : srt_pkg::ST_RANGE;
          end
          default: begin
            status_next = srt_pkg::ST_RANGE;
          end
        endcase
      end
      default: begin
        state_next = srt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      year_q <= key_year;
      flow_q <= flow_value;
      pos_q  <= read_position;
    end
    if (exec) begin
      status       <= status_next;
      record_count <= srt_pkg::RCNT_W'(count_next);
      if (op_q == srt_pkg::OP_READ && rd_ok) begin
        found_year <= or_year;
        found_flow <= or_flow;
      end else begin
        found_year <= '0;
        found_flow <= '0;
      end
    end
  end

endmodule
